@@ rtl/byte_list_literal_parser_macros.svh @@
// Assertion shorthands for the byte list literal parser.
// Both sample on clk and stay quiet while rst_n is low.
`ifndef BYTE_LIST_LITERAL_PARSER_MACROS_SVH
`define BYTE_LIST_LITERAL_PARSER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BLP_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BLP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/blp_pkg.sv @@
package blp_pkg;

  typedef enum logic [3:0] {
    PH_ITEM  = 4'd0,
    PH_DEC   = 4'd1,
    PH_HEX   = 4'd2,
    PH_BIN   = 4'd3,
    PH_CQ1   = 4'd4,
    PH_CQ2   = 4'd5,
    PH_STR   = 4'd6,
    PH_AFTER = 4'd7,
    PH_STOP  = 4'd8
  } phase_t;

  localparam logic [6:0] CH_END     = 7'h00;
  localparam logic [6:0] CH_TAB     = 7'h09;
  localparam logic [6:0] CH_SPACE   = 7'h20;
  localparam logic [6:0] CH_DQUOTE  = 7'h22;
  localparam logic [6:0] CH_DOLLAR  = 7'h24;
  localparam logic [6:0] CH_PERCENT = 7'h25;
  localparam logic [6:0] CH_APOS    = 7'h27;
  localparam logic [6:0] CH_COMMA   = 7'h2C;
  localparam logic [6:0] CH_ZERO    = 7'h30;
  localparam logic [6:0] CH_ONE     = 7'h31;
  localparam logic [6:0] CH_NINE    = 7'h39;
  localparam logic [6:0] CH_UA      = 7'h41;
  localparam logic [6:0] CH_UF      = 7'h46;
  localparam logic [6:0] CH_LA      = 7'h61;
  localparam logic [6:0] CH_LF      = 7'h66;

  localparam logic [7:0] MAX_VALUES_RST = 8'd16;

  // One result record.
  typedef struct packed {
    logic [7:0] value;
    logic       is_total;
    logic [7:0] total_count;
  } rec_t;

  // Up to two records pushed in one cycle; v1 only together with v0.
  typedef struct packed {
    logic v0;
    logic v1;
    rec_t r0;
    rec_t r1;
  } push_t;

  function automatic logic is_blank(input logic [6:0] c);
    return (c == CH_SPACE) || (c == CH_TAB);
  endfunction

  function automatic logic is_dec(input logic [6:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

  // Returns {valid, nibble}.
  function automatic logic [4:0] hex_digit(input logic [6:0] c);
    logic [4:0] res;
    res = 5'd0;
    if (is_dec(c)) begin
      res = {1'b1, c[3:0]};
    end else if (((c >= CH_LA) && (c <= CH_LF)) || ((c >= CH_UA) && (c <= CH_UF))) begin
      res = {1'b1, c[3:0] + 4'd9};
    end
    return res;
  endfunction

endpackage

@@ rtl/blp_outq.sv @@
module blp_outq #(
  parameter int DEPTH = 4
) (
  input  logic           clk,
  input  logic           rst_n,
  input  blp_pkg::push_t push,
  output logic           room2,
  output logic           pop_valid,
  input  logic           pop_ready,
  output blp_pkg::rec_t  pop_rec
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  blp_pkg::rec_t   mem_r [DEPTH];
  logic [AW-1:0]   wp_r, wp_nxt, rp_r, rp_nxt, wp1, wp2;
  logic [CW-1:0]   cnt_r, cnt_nxt;
  logic [1:0]      n_push;
  logic            pop;

  function automatic logic [AW-1:0] next_ptr(input logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign wp1       = next_ptr(wp_r);
  assign wp2       = next_ptr(wp1);
  assign pop_valid = (cnt_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_rec   = mem_r[rp_r];
  // Leave room for a two-record push regardless of a pop this cycle.
  assign room2     = (cnt_r <= CW'(DEPTH - 2));
  assign n_push    = {1'b0, push.v0} + {1'b0, push.v1};

  always_comb begin
    cnt_nxt = cnt_r + CW'(n_push) - CW'(pop);
    rp_nxt  = pop ? next_ptr(rp_r) : rp_r;
    wp_nxt  = push.v1 ? wp2 : (push.v0 ? wp1 : wp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push.v0) begin
      mem_r[wp_r] <= push.r0;
    end
    if (push.v1) begin
      mem_r[wp1] <= push.r1;
    end
  end

endmodule

@@ rtl/byte_list_literal_parser.sv @@
// Flow: an accepted character waits in the input stage until the queue can take two
// records; its records then enter the result queue, which drives out_tvalid.
// Throughput: one character per cycle while room2 holds; the end of text character may
// push a value plus a total, taking two output transfers.
// Reset: synchronous active-low rst_n clears parser state, queue and stage; max_values
// returns to 16.
`include "byte_list_literal_parser_macros.svh"

module byte_list_literal_parser #(
  parameter int QUEUE_DEPTH = 4
) (
  input  logic        clk,
  input  logic        rst_n,
  // Configuration: max_values
  input  logic        cfg_we,
  input  logic [7:0]  cfg_wdata,
  // Input stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [6:0] ch, [7] zero pad
  // Result stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] value, [15:8] total_count
  output logic        out_tuser   // [0] is_total
);

  // Configuration register
  logic [7:0] max_values_r;

  // Input stage: holds one character until the queue can take its records
  logic       s_valid_r, s_valid_nxt;
  logic [6:0] s_ch_r;

  // Parser state
  blp_pkg::phase_t phase_r, phase_nxt;
  logic [15:0]     acc_r, acc_nxt;
  logic [7:0]      cnt_r, cnt_nxt;
  logic [6:0]      qc_r, qc_nxt;

  logic            room2;
  logic            fire;
  logic            in_take;
  blp_pkg::push_t  push;
  blp_pkg::rec_t   head;
  logic            val_emit;

  // Helper decodes of the staged character
  logic            under_max;
  logic            num_phase;
  logic            lit_cont;
  logic [4:0]      hexd;
  logic [6:0]      c;

  assign c         = s_ch_r;
  assign fire      = s_valid_r && room2;
  assign in_tready = !s_valid_r || room2;
  assign in_take   = in_tvalid && in_tready;
  assign hexd      = blp_pkg::hex_digit(c);
  assign under_max = (cnt_r < max_values_r);
  assign num_phase = (phase_r == blp_pkg::PH_DEC) || (phase_r == blp_pkg::PH_HEX) ||
                     (phase_r == blp_pkg::PH_BIN);
  // Does this character extend the pending number literal?
  assign lit_cont  = ((phase_r == blp_pkg::PH_DEC) && blp_pkg::is_dec(c)) ||
                     ((phase_r == blp_pkg::PH_HEX) && hexd[4]) ||
                     ((phase_r == blp_pkg::PH_BIN) &&
                      ((c == blp_pkg::CH_ZERO) || (c == blp_pkg::CH_ONE)));

  // What may follow a finished item: blanks, then a comma, else stop until end of text.
  function automatic blp_pkg::phase_t after_item(input logic [6:0] ch);
    blp_pkg::phase_t ph;
    if (blp_pkg::is_blank(ch)) begin
      ph = blp_pkg::PH_AFTER;
    end else if (ch == blp_pkg::CH_COMMA) begin
      ph = blp_pkg::PH_ITEM;
    end else begin
      ph = blp_pkg::PH_STOP;
    end
    return ph;
  endfunction

  // Output decode: records produced by the staged character
  always_comb begin
    push     = '0;
    val_emit = 1'b0;
    if (fire) begin
      if (c == blp_pkg::CH_END) begin
        // Flush a pending number first, then the total record
        if (num_phase && under_max && !acc_r[15]) begin
          push.v0          = 1'b1;
          push.r0.value    = acc_r[7:0];
          val_emit         = 1'b1;
          push.v1          = 1'b1;
          push.r1.is_total = 1'b1;
          push.r1.total_count = cnt_r + 8'd1;
        end else begin
          push.v0          = 1'b1;
          push.r0.is_total = 1'b1;
          push.r0.total_count = cnt_r;
        end
      end else if ((phase_r != blp_pkg::PH_STOP) && under_max) begin
        unique case (phase_r)
          blp_pkg::PH_DEC, blp_pkg::PH_HEX, blp_pkg::PH_BIN: begin
            // Terminating character: emit the literal unless bit 15 kills it
            if (!lit_cont && !acc_r[15]) begin
              push.v0       = 1'b1;
              push.r0.value = acc_r[7:0];
              val_emit      = 1'b1;
            end
          end
          blp_pkg::PH_CQ2: begin
            if (c == blp_pkg::CH_APOS) begin
              push.v0       = 1'b1;
              push.r0.value = {1'b0, qc_r};
              val_emit      = 1'b1;
            end
          end
          blp_pkg::PH_STR: begin
            if (c != blp_pkg::CH_DQUOTE) begin
              push.v0       = 1'b1;
              push.r0.value = {1'b0, c};
              val_emit      = 1'b1;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  // Next-state decode
  always_comb begin
    phase_nxt = phase_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r + {7'd0, val_emit};
    qc_nxt    = qc_r;
    if (fire) begin
      if (c == blp_pkg::CH_END) begin
        // Re-arm for the next text
        phase_nxt = blp_pkg::PH_ITEM;
        acc_nxt   = 16'd0;
        cnt_nxt   = 8'd0;
        qc_nxt    = 7'd0;
      end else if (phase_r == blp_pkg::PH_STOP) begin
        // Hold: drop everything up to end of text
      end else if (!under_max) begin
        phase_nxt = blp_pkg::PH_STOP;
      end else begin
        unique case (phase_r)
          blp_pkg::PH_ITEM: begin
            if (!blp_pkg::is_blank(c)) begin
              acc_nxt = 16'd0;
              if (c == blp_pkg::CH_DQUOTE) begin
                phase_nxt = blp_pkg::PH_STR;
              end else if (c == blp_pkg::CH_APOS) begin
                phase_nxt = blp_pkg::PH_CQ1;
              end else if (c == blp_pkg::CH_DOLLAR) begin
                phase_nxt = blp_pkg::PH_HEX;
              end else if (c == blp_pkg::CH_PERCENT) begin
                phase_nxt = blp_pkg::PH_BIN;
              end else if (blp_pkg::is_dec(c)) begin
                acc_nxt   = {12'd0, c[3:0]};
                phase_nxt = blp_pkg::PH_DEC;
              end else begin
                phase_nxt = blp_pkg::PH_STOP;
              end
            end
          end
          blp_pkg::PH_DEC, blp_pkg::PH_HEX, blp_pkg::PH_BIN: begin
            if (lit_cont) begin
              if (phase_r == blp_pkg::PH_DEC) begin
                // acc * 10 + digit, wrapping at 16 bits
                acc_nxt = {acc_r[12:0], 3'b000} + {acc_r[14:0], 1'b0} + {12'd0, c[3:0]};
              end else if (phase_r == blp_pkg::PH_HEX) begin
                acc_nxt = {acc_r[11:0], hexd[3:0]};
              end else begin
                acc_nxt = {acc_r[14:0], c[0]};
              end
            end else if (acc_r[15]) begin
              phase_nxt = blp_pkg::PH_STOP;
            end else begin
              phase_nxt = after_item(c);
            end
          end
          blp_pkg::PH_CQ1: begin
            qc_nxt    = c;
            phase_nxt = blp_pkg::PH_CQ2;
          end
          blp_pkg::PH_CQ2: begin
            phase_nxt = (c == blp_pkg::CH_APOS) ? blp_pkg::PH_AFTER : blp_pkg::PH_STOP;
          end
          blp_pkg::PH_STR: begin
            if (c == blp_pkg::CH_DQUOTE) begin
              phase_nxt = blp_pkg::PH_AFTER;
            end
          end
          blp_pkg::PH_AFTER: begin
            if (!blp_pkg::is_blank(c)) begin
              phase_nxt = (c == blp_pkg::CH_COMMA) ? blp_pkg::PH_ITEM : blp_pkg::PH_STOP;
            end
          end
          default: begin
            phase_nxt = blp_pkg::PH_STOP;
          end
        endcase
      end
    end
  end

  // Advance the stage: load on an input transfer, empty once parsed
  always_comb begin
    if (in_take) begin
      s_valid_nxt = 1'b1;
    end else if (fire) begin
      s_valid_nxt = 1'b0;
    end else begin
      s_valid_nxt = s_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_values_r <= blp_pkg::MAX_VALUES_RST;
      s_valid_r    <= 1'b0;
      phase_r      <= blp_pkg::PH_ITEM;
      acc_r        <= 16'd0;
      cnt_r        <= 8'd0;
      qc_r         <= 7'd0;
    end else begin
      if (cfg_we) begin
        max_values_r <= cfg_wdata;
      end
      s_valid_r <= s_valid_nxt;
      phase_r   <= phase_nxt;
      acc_r     <= acc_nxt;
      cnt_r     <= cnt_nxt;
      qc_r      <= qc_nxt;
    end
  end

  // Character payload needs no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      s_ch_r <= in_tdata[6:0];
    end
  end

  // Result queue parts the parser from the output handshake
  blp_outq #(
    .DEPTH (QUEUE_DEPTH)
  ) u_outq (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .room2     (room2),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_rec   (head)
  );

  assign out_tdata = {head.total_count, head.value};
  assign out_tuser = head.is_total;

  // End of text must re-arm the parser
  `BLP_ASSERT_NEXT(a_end_rearms, fire && (s_ch_r == blp_pkg::CH_END), (phase_r == blp_pkg::PH_ITEM) && (cnt_r == 8'd0) && (acc_r == 16'd0), "parser not re-armed after end of text")
  // Stopped parser stays silent and stopped until end of text
  `BLP_ASSERT_SAME(a_stop_silent, fire && (s_ch_r != blp_pkg::CH_END) && (phase_r == blp_pkg::PH_STOP), !push.v0 && (phase_nxt == blp_pkg::PH_STOP), "stopped parser produced a record")
  // A second record only ever follows a flushed value at end of text
  `BLP_ASSERT_SAME(a_pair_is_total, push.v1, push.v0 && !push.r0.is_total && push.r1.is_total && (s_ch_r == blp_pkg::CH_END), "malformed record pair")

endmodule
